FILE: rtl/rhythmic_gate_pattern_sequencer_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the rhythmic gate pattern sequencer
// Immediate-overlap and next-cycle implication checks on the local clock.
// ----------------------------------------------------------------------------
`ifndef RHYTHMIC_GATE_PATTERN_SEQUENCER_CORE_MACROS_SVH
`define RHYTHMIC_GATE_PATTERN_SEQUENCER_CORE_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define RGPS_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define RGPS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/rgps_pkg.sv
// ----------------------------------------------------------------------------
// rgps_pkg
// Shared types, register codes and the fixed rhythm pattern ROM.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rgps_pkg;

  localparam int DEF_NUM_PATTERNS = 14;
  localparam int DEF_MAX_STEPS    = 16;

  localparam int ROM_ROWS = 14;
  localparam int ROM_COLS = 16;
  localparam int STEP_W   = 4;
  localparam int LEN_W    = 6;

  localparam logic [31:0] RST_PHASE_STEP  = 32'd8947849;
  localparam logic [15:0] RST_PULSE_WIDTH = 16'd32768;
  localparam logic [15:0] RST_LEVEL       = 16'd32768;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_PHASE_STEP     = 2'd0,
    REG_PULSE_WIDTH    = 2'd1,
    REG_LEVEL          = 2'd2,
    REG_PATTERN_SELECT = 2'd3
  } reg_idx_t;

  // Note length codes
  localparam logic [1:0] NL_16TH = 2'd0;
  localparam logic [1:0] NL_8TH  = 2'd1;
  localparam logic [1:0] NL_QTR  = 2'd2;

  // Note codes: bit 0 active, bits 2:1 length
  localparam logic [2:0] R16 = 3'd0;
  localparam logic [2:0] A16 = 3'd1;
  localparam logic [2:0] A8  = 3'd3;
  localparam logic [2:0] A4  = 3'd5;

  typedef struct packed {
    logic [31:0] phase_step;
    logic [15:0] pulse_width;
    logic [15:0] level;
    logic [3:0]  pattern_select;
  } cfg_t;

  typedef struct packed {
    logic [15:0] gate_level;
    logic        cycle_end;
    logic        half_crossed;
  } res_t;

  localparam logic [4:0] ROM_LEN [ROM_ROWS] = '{
    5'd16, 5'd16, 5'd8, 5'd16, 5'd4, 5'd16, 5'd16, 5'd16,
    5'd12, 5'd12, 5'd12, 5'd12, 5'd14, 5'd14
  };

  localparam logic [2:0] ROM_NOTE [ROM_ROWS][ROM_COLS] = '{
    '{A16, A16, A16, A16, A16, A16, A16, A16, A16, A16, A16, A16, A16, A16, A16, A16},
    '{A16, R16, A16, R16, A16, R16, A16, R16, A16, R16, A16, R16, A16, R16, A16, R16},
    '{A8,  A8,  A8,  A8,  A8,  A8,  A8,  A8,  R16, R16, R16, R16, R16, R16, R16, R16},
    '{A16, R16, R16, R16, A16, R16, R16, R16, A16, R16, R16, R16, A16, R16, R16, R16},
    '{A4,  A4,  A4,  A4,  R16, R16, R16, R16, R16, R16, R16, R16, R16, R16, R16, R16},
    '{A16, R16, A16, R16, A16, R16, A16, R16, A16, R16, A16, R16, A16, R16, A16, R16},
    '{A16, A16, R16, R16, A16, A16, R16, R16, A16, A16, R16, R16, A16, A16, R16, R16},
    '{A16, A16, A16, R16, A16, A16, A16, R16, A16, A16, A16, R16, A16, A16, A16, R16},
    '{A8,  A16, A16, A8,  A16, A16, A8,  A16, A16, A8,  A16, A16, R16, R16, R16, R16},
    '{A4,  A8,  A8,  A4,  A8,  A8,  A4,  A8,  A8,  A4,  A8,  A8,  R16, R16, R16, R16},
    '{A16, A8,  A8,  A16, A8,  A8,  A16, A8,  A8,  A16, A8,  A8,  R16, R16, R16, R16},
    '{A8,  A4,  A4,  A8,  A4,  A4,  A8,  A4,  A4,  A8,  A4,  A4,  R16, R16, R16, R16},
    '{A16, A16, A16, A16, A16, A16, A8,  A16, A16, A16, A16, A16, A16, A8,  R16, R16},
    '{A8,  A16, A16, A16, A16, A16, A16, A8,  A16, A16, A16, A16, A16, A16, A16, A16}
  };

  // Rows without ROM contents read as length zero
  function automatic logic [4:0] rom_len_lookup(input logic [3:0] p);
    logic [4:0] r;
    r = 5'd0;
    if ({28'd0, p} < ROM_ROWS) begin
      r = ROM_LEN[p];
    end
    return r;
  endfunction

  // Rows without ROM contents read as inactive sixteenths
  function automatic logic [2:0] rom_note_lookup(input logic [3:0] p, input logic [3:0] s);
    logic [2:0] r;
    r = R16;
    if ({28'd0, p} < ROM_ROWS) begin
      r = ROM_NOTE[p][s];
    end
    return r;
  endfunction

endpackage

FILE: rtl/rgps_engine.sv
// ----------------------------------------------------------------------------
// rgps_engine
// Phase accumulator, pattern step state and gate decision for one sample.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "rhythmic_gate_pattern_sequencer_core_macros.svh"

module rgps_engine
  import rgps_pkg::*;
#(
  parameter int MAX_STEPS = DEF_MAX_STEPS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        fire,
  input  logic        cmd_resync,
  input  logic [31:0] start_phase,
  input  cfg_t        cfg,
  output res_t        res
);

  logic [31:0]       phase_r, phase_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [1:0]        lastq_r, lastq_nxt;
  logic              qv_r, qv_nxt;
  logic              note_on_r, note_on_nxt;
  logic [1:0]        note_len_r, note_len_nxt;

  logic [1:0]        quad;
  logic              load;
  logic [4:0]        rom_len;
  logic [LEN_W-1:0]  pat_len;
  logic [2:0]        note;
  logic              adv;
  logic [LEN_W-1:0]  step_inc;
  logic              open;
  logic [32:0]       phase_sum;
  logic              wrap;
  logic              half;

  always_comb begin
    quad     = phase_r[31:30];
    load     = !qv_r || (quad != lastq_r);
    rom_len  = rom_len_lookup(cfg.pattern_select);
    pat_len  = ({1'b0, rom_len} > LEN_W'(MAX_STEPS)) ? LEN_W'(MAX_STEPS) : {1'b0, rom_len};
    note     = rom_note_lookup(cfg.pattern_select, step_r);
    step_inc = LEN_W'(step_r) + LEN_W'(1);

    // sixteenths advance on every quadrant, eighths on odd quadrants, quarters on the last one
    case (note[2:1])
      NL_16TH: adv = 1'b1;
      NL_8TH:  adv = quad[0];
      NL_QTR:  adv = (quad == 2'd3);
      default: adv = 1'b0;
    endcase

    note_on_nxt  = load ? note[0]   : note_on_r;
    note_len_nxt = load ? note[2:1] : note_len_r;
    lastq_nxt    = load ? quad      : lastq_r;
    qv_nxt       = 1'b1;
    step_nxt     = step_r;
    if (load && adv) begin
      step_nxt = (step_inc >= pat_len) ? '0 : step_inc[STEP_W-1:0];
    end

    // gate compare inside the span of the current note
    case (note_len_nxt)
      NL_16TH: open = phase_r[29:0] < {cfg.pulse_width, 14'd0};
      NL_8TH:  open = phase_r[30:0] < {cfg.pulse_width, 15'd0};
      default: open = phase_r < {cfg.pulse_width, 16'd0};
    endcase

    phase_sum = {1'b0, phase_r} + {1'b0, cfg.phase_step};
    wrap      = phase_sum[32];
    half      = wrap ? phase_sum[31] : (!phase_r[31] && phase_sum[31]);
    phase_nxt = phase_sum[31:0];

    res.gate_level   = (open && note_on_nxt) ? cfg.level : 16'd0;
    res.cycle_end    = wrap;
    res.half_crossed = half;

    // resync: load phase, rewind step, force reload, output silence
    if (cmd_resync) begin
      phase_nxt    = start_phase;
      step_nxt     = '0;
      qv_nxt       = 1'b0;
      lastq_nxt    = lastq_r;
      note_on_nxt  = note_on_r;
      note_len_nxt = note_len_r;
      res          = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= '0;
      step_r     <= '0;
      lastq_r    <= '0;
      qv_r       <= 1'b0;
      note_on_r  <= 1'b0;
      note_len_r <= NL_16TH;
    end else if (fire) begin
      phase_r    <= phase_nxt;
      step_r     <= step_nxt;
      lastq_r    <= lastq_nxt;
      qv_r       <= qv_nxt;
      note_on_r  <= note_on_nxt;
      note_len_r <= note_len_nxt;
    end
  end

  `RGPS_ASSERT_NEXT(a_resync_clears, fire && cmd_resync, !qv_r && (step_r == '0), "resync did not clear step and reload")
  `RGPS_ASSERT_NEXT(a_sample_loads, fire && !cmd_resync, qv_r && (lastq_r == $past(quad)), "sample left quadrant stale")
  `RGPS_ASSERT_NEXT(a_idle_holds, !fire, $stable(phase_r) && $stable(step_r), "state moved without a beat")
  `RGPS_ASSERT_SAME(a_gate_level, fire && (res.gate_level != 16'd0), !cmd_resync && note_on_nxt, "gate open on a rest or resync")

endmodule

FILE: rtl/rhythmic_gate_pattern_sequencer_core.sv
// ----------------------------------------------------------------------------
// rhythmic_gate_pattern_sequencer_core
// Pattern-driven tremolo gate: one sample beat in, one gated level beat out.
//
//   channel | dir | tdata (low bit up)                        | tuser
//   in_     | in  | start_phase[31:0]                         | command
//   out_    | out | gate_level[15:0], cycle_end, half_crossed | -
//   cfg_    | in  | index/wdata write port, no read-back      | -
//
// One beat per cycle sustained while out_tready is high; a beat passes from the input
// register to the output register, with the full sample update computed between them.
// Reset (rst_n low, synchronous) clears phase, step and config to defaults.
// A stalled output keeps one beat in the input register before in_tready drops.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rhythmic_gate_pattern_sequencer_core
  import rgps_pkg::*;
#(
  parameter int NUM_PATTERNS = DEF_NUM_PATTERNS,
  parameter int MAX_STEPS    = DEF_MAX_STEPS
) (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // start_phase[31:0]
  input  logic        in_tuser,   // command: 0 advance, 1 resync
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // gate_level[15:0], cycle_end, half_crossed, zero pad
  // configuration
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_wdata
);

  cfg_t        cfg_r;
  res_t        res;

  logic        s1_vld_r;
  logic        s1_cmd_r;
  logic [31:0] s1_phase_r;
  logic        out_vld_r;
  res_t        out_res_r;

  logic        out_free;
  logic        fire;

  assign out_free  = !out_vld_r || out_tready;
  assign fire      = s1_vld_r && out_free;
  assign in_tready = !s1_vld_r || out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.phase_step     <= RST_PHASE_STEP;
      cfg_r.pulse_width    <= RST_PULSE_WIDTH;
      cfg_r.level          <= RST_LEVEL;
      cfg_r.pattern_select <= 4'd0;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_PHASE_STEP:  cfg_r.phase_step  <= cfg_wdata;
        REG_PULSE_WIDTH: cfg_r.pulse_width <= cfg_wdata[15:0];
        REG_LEVEL:       cfg_r.level       <= cfg_wdata[15:0];
        REG_PATTERN_SELECT: begin
          // drop selects past the pattern count
          if ({28'd0, cfg_wdata[3:0]} < NUM_PATTERNS) begin
            cfg_r.pattern_select <= cfg_wdata[3:0];
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_tready) begin
      s1_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_cmd_r   <= in_tuser;
      s1_phase_r <= in_tdata;
    end
  end

  rgps_engine #(
    .MAX_STEPS (MAX_STEPS)
  ) u_engine (
    .clk         (clk),
    .rst_n       (rst_n),
    .fire        (fire),
    .cmd_resync  (s1_cmd_r),
    .start_phase (s1_phase_r),
    .cfg         (cfg_r),
    .res         (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_free) begin
      out_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {6'd0, out_res_r.half_crossed, out_res_r.cycle_end, out_res_r.gate_level};

endmodule

FILE: dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the rhythmic gate pattern sequencer. A cycle-level
// predictor of the phase accumulator, quadrant tracking, pattern stepping and
// gate compare runs on every accepted input beat. Each output beat is checked
// field by field against the oldest prediction. Directed corner cases come
// first, then randomized register settings with random sample streams. Both
// stream sides idle and stall at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import rgps_pkg::*;

  localparam int RUN_LIMIT = 400000;

  typedef struct {
    logic        command;
    logic [31:0] start_phase;
  } sample_beat_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = 32'd0;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = REG_PHASE_STEP;
  logic [31:0] cfg_wdata = 32'd0;

  rhythmic_gate_pattern_sequencer_core u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  sample_beat_t pending_beats[$];
  res_t         expected_gates[$];
  int           mismatch_count = 0;
  int           cycle_count = 0;
  int           idle_max = 8;
  logic         in_fire = 1'b0;
  logic         out_fire = 1'b0;
  int           in_gap = 0;
  int           out_wait = 0;
  sample_beat_t next_beat;
  res_t         want;
  res_t         got;

  // Predictor mirror of the register file
  logic [31:0] m_phase_step = RST_PHASE_STEP;
  logic [15:0] m_pulse_width = RST_PULSE_WIDTH;
  logic [15:0] m_level = RST_LEVEL;
  logic [3:0]  m_pattern = 4'd0;

  // Predictor copy of the sequencer state
  logic [31:0] seq_phase = 32'd0;
  logic [3:0]  seq_step = 4'd0;
  logic [1:0]  seq_quad = 2'd0;
  logic        seq_quad_seen = 1'b0;
  logic        seq_note_on = 1'b0;
  logic [1:0]  seq_note_len = NL_16TH;

  function automatic res_t gate_sample(input logic cmd, input logic [31:0] start_phase);
    res_t        r;
    logic [1:0]  q;
    logic [2:0]  note;
    logic [31:0] nxt;
    int          len;
    logic        advance;
    logic        open;
    r = '0;
    if (cmd) begin
      seq_phase = start_phase;
      seq_step = 4'd0;
      seq_quad_seen = 1'b0;
      return r;
    end
    q = seq_phase[31:30];
    if (!seq_quad_seen || q != seq_quad) begin
      len = 0;
      note = R16;
      if (m_pattern < ROM_ROWS) begin
        len = ROM_LEN[m_pattern];
        note = ROM_NOTE[m_pattern][seq_step];
      end
      if (len > DEF_MAX_STEPS) len = DEF_MAX_STEPS;
      seq_note_on = note[0];
      seq_note_len = note[2:1];
      advance = (seq_note_len == NL_16TH) ||
                (seq_note_len == NL_8TH && q[0]) ||
                (seq_note_len == NL_QTR && q == 2'd3);
      if (advance) begin
        if (int'(seq_step) + 1 >= len) seq_step = 4'd0;
        else seq_step = seq_step + 4'd1;
      end
      seq_quad = q;
      seq_quad_seen = 1'b1;
    end
    // gate threshold scales with the span of the current note
    if (seq_note_len == NL_16TH) begin
      open = {2'b00, seq_phase[29:0]} < {2'b00, m_pulse_width, 14'd0};
    end else if (seq_note_len == NL_8TH) begin
      open = {1'b0, seq_phase[30:0]} < {1'b0, m_pulse_width, 15'd0};
    end else begin
      open = seq_phase < {m_pulse_width, 16'd0};
    end
    r.gate_level = (open && seq_note_on) ? m_level : 16'd0;
    nxt = seq_phase + m_phase_step;
    r.cycle_end = nxt < seq_phase;
    if (r.cycle_end) r.half_crossed = nxt[31];
    else r.half_crossed = !seq_phase[31] && nxt[31];
    seq_phase = nxt;
    return r;
  endfunction

  initial begin
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > RUN_LIMIT) begin
      $display("rhythmic_gate_pattern_sequencer_core verification failed");
      $finish;
    end
  end

  // Input side: record accepted beats and predict their results
  always @(posedge clk) begin
    if (!rst_n) begin
      in_fire <= 1'b0;
    end else begin
      in_fire <= in_tvalid && in_tready;
      if (in_tvalid && in_tready) expected_gates.push_back(gate_sample(in_tuser, in_tdata));
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_gap = $urandom_range(0, idle_max);
    end else if (in_tvalid && !in_fire) begin
      // hold the beat until it is taken
    end else if (in_gap > 0) begin
      in_tvalid <= 1'b0;
      in_gap--;
    end else if (pending_beats.size() > 0) begin
      next_beat = pending_beats.pop_front();
      in_tvalid <= 1'b1;
      in_tdata <= next_beat.start_phase;
      in_tuser <= next_beat.command;
      in_gap = $urandom_range(0, idle_max);
    end else begin
      in_tvalid <= 1'b0;
    end
  end

  // Output side: random stall before each beat
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      out_wait = $urandom_range(0, idle_max);
    end else begin
      if (out_fire) out_wait = $urandom_range(0, idle_max);
      if (out_wait > 0) begin
        out_tready <= 1'b0;
        out_wait--;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_fire <= 1'b0;
    end else begin
      out_fire <= out_tvalid && out_tready;
      if (out_tvalid && out_tready) begin
        got.gate_level = out_tdata[15:0];
        got.cycle_end = out_tdata[16];
        got.half_crossed = out_tdata[17];
        if (expected_gates.size() == 0) begin
          $display("%0t: unexpected beat, expected none, actual %h", $time, out_tdata);
          mismatch_count++;
        end else begin
          want = expected_gates.pop_front();
          if (got.gate_level !== want.gate_level) begin
            $display("%0t: gate_level expected %h actual %h", $time,
                     want.gate_level, got.gate_level);
            mismatch_count++;
          end
          if (got.cycle_end !== want.cycle_end) begin
            $display("%0t: cycle_end expected %b actual %b", $time,
                     want.cycle_end, got.cycle_end);
            mismatch_count++;
          end
          if (got.half_crossed !== want.half_crossed) begin
            $display("%0t: half_crossed expected %b actual %b", $time,
                     want.half_crossed, got.half_crossed);
            mismatch_count++;
          end
        end
      end
    end
  end

  task automatic write_reg(input reg_idx_t idx, input logic [31:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_PHASE_STEP:  m_phase_step = data;
      REG_PULSE_WIDTH: m_pulse_width = data[15:0];
      REG_LEVEL:       m_level = data[15:0];
      default: begin
        // out-of-range pattern indexes leave the selection alone
        if (data[3:0] < DEF_NUM_PATTERNS) m_pattern = data[3:0];
      end
    endcase
  endtask

  task automatic push_beat(input logic cmd, input logic [31:0] start_phase);
    sample_beat_t b;
    b.command = cmd;
    b.start_phase = start_phase;
    pending_beats.push_back(b);
  endtask

  // Wait until every queued beat is taken and every result is back
  task automatic drain();
    @(posedge clk);
    while (pending_beats.size() != 0 || in_tvalid || expected_gates.size() != 0)
      @(posedge clk);
  endtask

  task automatic push_advances(input int n);
    repeat (n) push_beat(1'b0, $urandom);
  endtask

  function automatic logic [31:0] pick_phase_step();
    logic [31:0] v;
    case ($urandom_range(0, 7))
      0: v = 32'd0;
      1: v = 32'hFFFF_FFFF;
      2: v = 32'h4000_0000;
      3: v = 32'h8000_0000;
      4: v = $urandom;
      7: v = $urandom_range(1, 32'h00FF_FFFF);
      default: v = $urandom_range(32'h0400_0000, 32'h4800_0000);
    endcase
    return v;
  endfunction

  function automatic logic [15:0] pick_q16();
    logic [15:0] v;
    case ($urandom_range(0, 5))
      0: v = 16'h0000;
      1: v = 16'hFFFF;
      default: v = $urandom_range(0, 16'hFFFF);
    endcase
    return v;
  endfunction

  function automatic logic [31:0] pick_start_phase();
    logic [31:0] v;
    case ($urandom_range(0, 7))
      0: v = 32'h0000_0000;
      1: v = 32'hFFFF_FFFF;
      2: v = 32'h7FFF_FFFF;
      3: v = 32'h8000_0000;
      default: v = $urandom;
    endcase
    return v;
  endfunction

  initial begin
    logic [31:0] d;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset defaults: first load after reset, half crossing and wrap
    push_advances(2);
    push_beat(1'b1, 32'h7FFF_FFFF);
    push_advances(1);
    push_beat(1'b1, 32'hFFFF_FFFF);
    push_advances(2);
    drain();

    // Full-scale step wraps every sample from a nonzero phase, closed gate; bad pattern indexes dropped
    write_reg(REG_PHASE_STEP, 32'hFFFF_FFFF);
    write_reg(REG_PULSE_WIDTH, 32'h0000_0000);
    write_reg(REG_LEVEL, 32'h0000_FFFF);
    write_reg(REG_PATTERN_SELECT, 32'h0000_000F);
    write_reg(REG_PATTERN_SELECT, 32'hFFFF_FFFE);
    @(posedge clk);
    push_beat(1'b1, 32'h0000_0000);
    push_advances(2);
    drain();

    // Quarter notes, one quadrant per sample, gate wide open
    write_reg(REG_PULSE_WIDTH, 32'h0000_FFFF);
    write_reg(REG_PHASE_STEP, 32'h4000_0000);
    write_reg(REG_PATTERN_SELECT, 32'd4);
    @(posedge clk);
    push_beat(1'b1, 32'h0000_0000);
    push_advances(4);
    drain();

    // Step past the length of a shorter pattern, then switch to it
    write_reg(REG_PATTERN_SELECT, 32'd0);
    @(posedge clk);
    push_beat(1'b1, 32'h0000_0000);
    push_advances(8);
    drain();
    write_reg(REG_PATTERN_SELECT, 32'd4);
    @(posedge clk);
    push_advances(2);
    drain();

    for (int ph = 0; ph < 12; ph++) begin
      idle_max = (ph == 3 || ph == 9) ? 0 : 8;
      if ($urandom_range(0, 3) != 0) write_reg(REG_PHASE_STEP, pick_phase_step());
      if ($urandom_range(0, 3) != 0) begin
        d = $urandom;
        d[15:0] = pick_q16();
        write_reg(REG_PULSE_WIDTH, d);
      end
      if ($urandom_range(0, 3) != 0) begin
        d = $urandom;
        d[15:0] = pick_q16();
        write_reg(REG_LEVEL, d);
      end
      if ($urandom_range(0, 3) != 0) begin
        d = ($urandom_range(0, 1) != 0) ? $urandom : 32'd0;
        d[3:0] = $urandom_range(0, 15);
        write_reg(REG_PATTERN_SELECT, d);
      end
      @(posedge clk);
      for (int i = 0; i < 75; i++) begin
        if ($urandom_range(0, 19) == 0) push_beat(1'b1, pick_start_phase());
        else push_beat(1'b0, $urandom);
        // mid-phase hold-off until the pipeline is empty
        if (ph == 6 && i == 37) drain();
      end
      drain();
    end

    repeat (10) @(posedge clk);
    if (mismatch_count == 0 && expected_gates.size() == 0) begin
      $display("rhythmic_gate_pattern_sequencer_core verification clean");
    end else begin
      $display("rhythmic_gate_pattern_sequencer_core verification failed");
    end
    $finish;
  end

endmodule
